FILE: hw/rtl/speed_limited_position_integrator_top_assert.svh
// Assertion macros for the speed-limited position integrator top level.
// Expects a clock named aclk and an active-low reset named aresetn in scope.
`ifndef SPEED_LIMITED_POSITION_INTEGRATOR_TOP_ASSERT_SVH
`define SPEED_LIMITED_POSITION_INTEGRATOR_TOP_ASSERT_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, checked out of reset
`define SLPI_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("slpi: same-cycle check failed");

// Next-cycle implication, checked out of reset
`define SLPI_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("slpi: next-cycle check failed");

`else

`define SLPI_ASSERT_IMP(lbl, ante, cons)
`define SLPI_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

FILE: hw/rtl/slpi_pkg.sv
// Shared types and codes for the speed-limited position integrator.
// Used by slpi_ctrl, slpi_dp and the top level; depends on nothing.
package slpi_pkg;

    // Item kinds
    localparam logic [1:0] OP_CMD     = 2'd0;
    localparam logic [1:0] OP_TICK    = 2'd1;
    localparam logic [1:0] OP_RESTART = 2'd2;

    // Configuration register indexes
    localparam logic [2:0] CFG_SPEED_LIMIT = 3'd0;
    localparam logic [2:0] CFG_TIMEOUT     = 3'd1;
    localparam logic [2:0] CFG_STEP_TIME   = 3'd2;
    localparam logic [2:0] CFG_START_X     = 3'd3;
    localparam logic [2:0] CFG_START_Y     = 3'd4;

    // Shared multiplier operand selects
    localparam logic [2:0] MUL_AX_SQ   = 3'd0;
    localparam logic [2:0] MUL_AY_SQ   = 3'd1;
    localparam logic [2:0] MUL_LIM_SQ  = 3'd2;
    localparam logic [2:0] MUL_VX_LIM  = 3'd3;
    localparam logic [2:0] MUL_VY_LIM  = 3'd4;
    localparam logic [2:0] MUL_VX_STEP = 3'd5;
    localparam logic [2:0] MUL_VY_STEP = 3'd6;

    // Controller to datapath commands
    typedef struct packed {
        logic       load_in;
        logic       restart;
        logic       clear_ticks;
        logic       tick_start;
        logic       mul_en;
        logic [2:0] mul_sel;
        logic       s2_load;
        logic       s2_acc;
        logic       vel_from_cmd;
        logic       sqrt_init;
        logic       sqrt_step;
        logic       div_init;
        logic       div_step;
        logic       wr_vx;
        logic       wr_vy;
        logic       pos_upd_x;
        logic       pos_upd_y;
        logic       load_out;
    } slpi_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic live;      // ticks since command below timeout
        logic over;      // squared speed above squared limit
        logic out_free;  // output register can take a result
    } slpi_stat_t;

endpackage

FILE: hw/rtl/speed_limited_position_integrator_top.sv
// Top level of the speed-limited position integrator.
// Depends on slpi_pkg, slpi_ctrl, slpi_dp and the assertion macro header.

// One item is worked on at a time. A live tick multiplies the x velocity by
// the step time, updates x while multiplying for y, then updates y and emits
// its result; a tick that has timed out goes straight to emitting. A restart
// or an ignored code is done when it is accepted. A command compares the sum
// of the squares of its parts with the squared limit; one within the speed
// limit is taken as the velocity as it is, and one above it is scaled by a
// bit-serial square root followed by two bit-serial divisions that share one
// 24x24 multiplier. A finished tick result sits in an output register, so the
// next item is accepted while it waits; a further tick holds only if that
// register is still full when it finishes. Configuration writes are always
// taken and are meant to be made while the block is idle.
module speed_limited_position_integrator_top (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_op,
    input  logic signed [23:0] s_cmd_vx,
    input  logic signed [23:0] s_cmd_vy,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_out_x,
    output logic signed [31:0] m_out_y,
    output logic               m_moved,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

`include "speed_limited_position_integrator_top_assert.svh"

    slpi_pkg::slpi_cmd_t  cmd;
    slpi_pkg::slpi_stat_t stat;

    // Configuration writes never stall
    assign cfg_ready = 1'b1;

    slpi_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_op    (s_op),
        .stat    (stat),
        .cmd     (cmd)
    );

    slpi_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_cmd_vx  (s_cmd_vx),
        .s_cmd_vy  (s_cmd_vy),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_out_x   (m_out_x),
        .m_out_y   (m_out_y),
        .m_moved   (m_moved)
    );

    // A result appears only when the controller loads the output register
    `SLPI_ASSERT_IMP(a_rise_needs_load, $rose(m_valid), $past(cmd.load_out))
    // A command transaction keeps the input closed on the next cycle
    `SLPI_ASSERT_NXT(a_cmd_busy, s_valid && s_ready && (s_op == slpi_pkg::OP_CMD), !s_ready)
    // Only a tick transaction can lead to a result
    `SLPI_ASSERT_NXT(a_no_result_non_tick, s_valid && s_ready && (s_op != slpi_pkg::OP_TICK), !$rose(m_valid))

endmodule

FILE: hw/rtl/slpi_ctrl.sv
// Controller state machine for the speed-limited position integrator.
// Depends on slpi_pkg; drives slpi_dp through slpi_cmd_t, reads slpi_stat_t.
module slpi_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [1:0]           s_op,
    input  slpi_pkg::slpi_stat_t stat,
    output slpi_pkg::slpi_cmd_t  cmd
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_SQX   = 4'd1;
    localparam logic [3:0] ST_SQY   = 4'd2;
    localparam logic [3:0] ST_LIM   = 4'd3;
    localparam logic [3:0] ST_CMP   = 4'd4;
    localparam logic [3:0] ST_SQRT  = 4'd5;
    localparam logic [3:0] ST_MULX  = 4'd6;
    localparam logic [3:0] ST_DIVX  = 4'd7;
    localparam logic [3:0] ST_MULY  = 4'd8;
    localparam logic [3:0] ST_DIVY  = 4'd9;
    localparam logic [3:0] ST_WRY   = 4'd10;
    localparam logic [3:0] ST_TMULX = 4'd11;
    localparam logic [3:0] ST_TADDX = 4'd12;
    localparam logic [3:0] ST_TADDY = 4'd13;
    localparam logic [3:0] ST_EMIT  = 4'd14;

    // 24 result bits for both the root and the quotients
    localparam logic [4:0] ITER_LAST = 5'd23;

    logic [3:0] state_reg, state_next;
    logic [4:0] cnt_reg, cnt_next;
    logic       accept;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;

    // Sequence the shared multiplier, root and divider
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    cmd.load_in = 1'b1;
                    case (s_op)
                        slpi_pkg::OP_CMD: begin
                            cmd.clear_ticks = 1'b1;
                            state_next      = ST_SQX;
                        end
                        slpi_pkg::OP_TICK: begin
                            cmd.tick_start = 1'b1;
                            state_next     = stat.live ? ST_TMULX : ST_EMIT;
                        end
                        slpi_pkg::OP_RESTART: begin
                            cmd.restart = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SQX: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = slpi_pkg::MUL_AX_SQ;
                state_next  = ST_SQY;
            end
            ST_SQY: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = slpi_pkg::MUL_AY_SQ;
                cmd.s2_load = 1'b1;
                state_next  = ST_LIM;
            end
            ST_LIM: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = slpi_pkg::MUL_LIM_SQ;
                cmd.s2_acc  = 1'b1;
                state_next  = ST_CMP;
            end
            ST_CMP: begin
                if (stat.over) begin
                    cmd.sqrt_init = 1'b1;
                    cnt_next      = '0;
                    state_next    = ST_SQRT;
                end else begin
                    cmd.vel_from_cmd = 1'b1;
                    state_next       = ST_IDLE;
                end
            end
            ST_SQRT: begin
                cmd.sqrt_step = 1'b1;
                cnt_next      = cnt_reg + 5'd1;
                if (cnt_reg == ITER_LAST) begin
                    state_next = ST_MULX;
                end
            end
            ST_MULX: begin
                cmd.mul_sel  = slpi_pkg::MUL_VX_LIM;
                cmd.div_init = 1'b1;
                cnt_next     = '0;
                state_next   = ST_DIVX;
            end
            ST_DIVX: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 5'd1;
                if (cnt_reg == ITER_LAST) begin
                    state_next = ST_MULY;
                end
            end
            ST_MULY: begin
                cmd.wr_vx    = 1'b1;
                cmd.mul_sel  = slpi_pkg::MUL_VY_LIM;
                cmd.div_init = 1'b1;
                cnt_next     = '0;
                state_next   = ST_DIVY;
            end
            ST_DIVY: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 5'd1;
                if (cnt_reg == ITER_LAST) begin
                    state_next = ST_WRY;
                end
            end
            ST_WRY: begin
                cmd.wr_vy  = 1'b1;
                state_next = ST_IDLE;
            end
            ST_TMULX: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = slpi_pkg::MUL_VX_STEP;
                state_next  = ST_TADDX;
            end
            ST_TADDX: begin
                cmd.pos_upd_x = 1'b1;
                cmd.mul_en    = 1'b1;
                cmd.mul_sel   = slpi_pkg::MUL_VY_STEP;
                state_next    = ST_TADDY;
            end
            ST_TADDY: begin
                cmd.pos_upd_y = 1'b1;
                state_next    = ST_EMIT;
            end
            ST_EMIT: begin
                // Hold until the output register frees up
                if (stat.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

FILE: hw/rtl/slpi_dp.sv
// Datapath for the speed-limited position integrator: state, configuration,
// shared multiplier, bit-serial root and divider. Depends on slpi_pkg.
module slpi_dp (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  slpi_pkg::slpi_cmd_t  cmd,
    output slpi_pkg::slpi_stat_t stat,
    input  logic                 cfg_valid,
    input  logic [2:0]           cfg_index,
    input  logic [31:0]          cfg_data,
    input  logic signed [23:0]   s_cmd_vx,
    input  logic signed [23:0]   s_cmd_vy,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic signed [31:0]   m_out_x,
    output logic signed [31:0]   m_out_y,
    output logic                 m_moved
);

    // Magnitude of a signed Q12.12 value; the most negative value maps to 2^23
    function automatic logic [23:0] mag24(input logic [23:0] v);
        mag24 = v[23] ? (~v + 24'd1) : v;
    endfunction

    // Add a signed step of magnitude d to pos, saturating to 32 bits
    function automatic logic [31:0] sat_step(input logic [31:0] pos,
                                             input logic neg,
                                             input logic [27:0] d);
        logic [33:0] dd;
        logic [33:0] sum;
        dd  = {6'd0, d};
        sum = {{2{pos[31]}}, pos} + (neg ? (~dd + 34'd1) : dd);
        if (sum[33] && !(sum[32] && sum[31])) begin
            sat_step = 32'h8000_0000;
        end else if (!sum[33] && (sum[32] || sum[31])) begin
            sat_step = 32'h7FFF_FFFF;
        end else begin
            sat_step = sum[31:0];
        end
    endfunction

    // Configuration
    logic [22:0] limit_reg;
    logic [15:0] timeout_reg;
    logic [15:0] step_reg;
    logic [31:0] start_x_reg;
    logic [31:0] start_y_reg;

    // Architectural state
    logic [31:0] pos_x_reg;
    logic [31:0] pos_y_reg;
    logic [23:0] vel_x_reg;
    logic [23:0] vel_y_reg;
    logic [15:0] ticks_reg;

    // Working registers
    logic [23:0] in_vx_reg;
    logic [23:0] in_vy_reg;
    logic [47:0] prod_reg;
    logic [47:0] s2_reg;
    logic [25:0] srem_reg;
    logic [23:0] root_reg;
    logic [23:0] drem_reg;
    logic [23:0] dq_reg;
    logic        moved_reg;

    // Output register
    logic        m_valid_reg;
    logic [31:0] out_x_reg;
    logic [31:0] out_y_reg;
    logic        out_moved_reg;

    logic [23:0] mul_a;
    logic [23:0] mul_b;
    logic [47:0] mul_p;
    logic [27:0] sq_shift;
    logic [27:0] sq_trial;
    logic        sq_ge;
    logic [24:0] dv_shift;
    logic        dv_ge;
    logic [23:0] quot_mag;
    logic [23:0] quot_signed;

    // Select multiplier operands
    always_comb begin
        case (cmd.mul_sel)
            slpi_pkg::MUL_AX_SQ: begin
                mul_a = mag24(in_vx_reg);
                mul_b = mag24(in_vx_reg);
            end
            slpi_pkg::MUL_AY_SQ: begin
                mul_a = mag24(in_vy_reg);
                mul_b = mag24(in_vy_reg);
            end
            slpi_pkg::MUL_LIM_SQ: begin
                mul_a = {1'b0, limit_reg};
                mul_b = {1'b0, limit_reg};
            end
            slpi_pkg::MUL_VX_LIM: begin
                mul_a = mag24(in_vx_reg);
                mul_b = {1'b0, limit_reg};
            end
            slpi_pkg::MUL_VY_LIM: begin
                mul_a = mag24(in_vy_reg);
                mul_b = {1'b0, limit_reg};
            end
            slpi_pkg::MUL_VX_STEP: begin
                mul_a = mag24(vel_x_reg);
                mul_b = {8'd0, step_reg};
            end
            slpi_pkg::MUL_VY_STEP: begin
                mul_a = mag24(vel_y_reg);
                mul_b = {8'd0, step_reg};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // Root: one result bit per cycle, two radicand bits brought down
    assign sq_shift = {srem_reg, s2_reg[47:46]};
    assign sq_trial = {2'b00, root_reg, 2'b01};
    assign sq_ge    = (sq_shift >= sq_trial);

    // Divider: one quotient bit per cycle, dividend bits shifted out of dq_reg
    assign dv_shift = {drem_reg, dq_reg[23]};
    assign dv_ge    = (dv_shift >= {1'b0, root_reg});

    // Scaled velocity takes the sign of the commanded part
    assign quot_mag    = dq_reg;
    assign quot_signed = ~quot_mag + 24'd1;

    assign stat.live     = (ticks_reg < timeout_reg);
    assign stat.over     = (s2_reg > prod_reg);
    assign stat.out_free = !m_valid_reg || m_ready;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg   <= 23'd4096;
            timeout_reg <= 16'd33;
            step_reg    <= 16'd1966;
            start_x_reg <= '0;
            start_y_reg <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                slpi_pkg::CFG_SPEED_LIMIT: limit_reg   <= cfg_data[22:0];
                slpi_pkg::CFG_TIMEOUT:     timeout_reg <= cfg_data[15:0];
                slpi_pkg::CFG_STEP_TIME:   step_reg    <= cfg_data[15:0];
                slpi_pkg::CFG_START_X:     start_x_reg <= cfg_data;
                slpi_pkg::CFG_START_Y:     start_y_reg <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Position, velocity and tick count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_x_reg <= '0;
            pos_y_reg <= '0;
            vel_x_reg <= '0;
            vel_y_reg <= '0;
            ticks_reg <= '0;
        end else begin
            if (cmd.restart) begin
                pos_x_reg <= start_x_reg;
                pos_y_reg <= start_y_reg;
                vel_x_reg <= '0;
                vel_y_reg <= '0;
            end
            if (cmd.restart || cmd.clear_ticks) begin
                ticks_reg <= '0;
            end else if (cmd.tick_start && (ticks_reg != 16'hFFFF)) begin
                ticks_reg <= ticks_reg + 16'd1;
            end
            if (cmd.vel_from_cmd) begin
                vel_x_reg <= in_vx_reg;
                vel_y_reg <= in_vy_reg;
            end
            if (cmd.wr_vx) begin
                vel_x_reg <= in_vx_reg[23] ? quot_signed : quot_mag;
            end
            if (cmd.wr_vy) begin
                vel_y_reg <= in_vy_reg[23] ? quot_signed : quot_mag;
            end
            if (cmd.pos_upd_x) begin
                pos_x_reg <= sat_step(pos_x_reg, vel_x_reg[23], prod_reg[39:12]);
            end
            if (cmd.pos_upd_y) begin
                pos_y_reg <= sat_step(pos_y_reg, vel_y_reg[23], prod_reg[39:12]);
            end
        end
    end

    // Working registers: latched item, product, root and divider
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            in_vx_reg <= s_cmd_vx;
            in_vy_reg <= s_cmd_vy;
        end
        if (cmd.tick_start) begin
            moved_reg <= stat.live;
        end
        if (cmd.mul_en) begin
            prod_reg <= mul_p;
        end
        if (cmd.s2_load) begin
            s2_reg <= prod_reg;
        end else if (cmd.s2_acc) begin
            s2_reg <= s2_reg + prod_reg;
        end else if (cmd.sqrt_step) begin
            s2_reg <= {s2_reg[45:0], 2'b00};
        end
        if (cmd.sqrt_init) begin
            srem_reg <= '0;
            root_reg <= '0;
        end else if (cmd.sqrt_step) begin
            srem_reg <= sq_ge ? 26'(sq_shift - sq_trial) : sq_shift[25:0];
            root_reg <= {root_reg[22:0], sq_ge};
        end
        if (cmd.div_init) begin
            drem_reg <= mul_p[47:24];
            dq_reg   <= mul_p[23:0];
        end else if (cmd.div_step) begin
            drem_reg <= dv_ge ? 24'(dv_shift - {1'b0, root_reg}) : dv_shift[23:0];
            dq_reg   <= {dq_reg[22:0], dv_ge};
        end
    end

    // Output register: hold a result until it is taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_x_reg     <= pos_x_reg;
            out_y_reg     <= pos_y_reg;
            out_moved_reg <= moved_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_out_x = out_x_reg;
    assign m_out_y = out_y_reg;
    assign m_moved = out_moved_reg;

endmodule
